/* hdl/mfp_pkg.sv */
// ----------------------------------------------------------------------------
// mfp_pkg
// Types, constants and helpers shared by the Fibonacci matrix power block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mfp_pkg;

	localparam int INDEX_BITS = 63;
	localparam int VALUE_BITS = 30;
	localparam int IN_TDATA_BITS = 64;
	localparam int OUT_TDATA_BITS = 32;

	// Width of the shared multiplier operands and product
	localparam int MUL_BITS = 33;
	localparam int PROD_BITS = 2 * MUL_BITS;
	// Sum of two products of residues stays below 2^61
	localparam int SUM_BITS = 61;
	// Remainder after the Barrett estimate stays below three times the prime
	localparam int REM_BITS = 32;

	localparam logic [VALUE_BITS-1:0] PRIME = 30'd1000000009;
	localparam logic [REM_BITS-1:0] PRIME_X1 = 32'd1000000009;
	localparam logic [REM_BITS-1:0] PRIME_X2 = 32'd2000000018;
	// Barrett reciprocal: floor(2^62 / prime)
	localparam logic [MUL_BITS-1:0] BARRETT_MU = 33'((64'd1 << 62) / 64'd1000000009);

	typedef enum logic [2:0] {
		OP_IDLE,
		OP_MUL_FIRST,
		OP_MUL_SECOND,
		OP_ADD,
		OP_MUL_MU,
		OP_MUL_P,
		OP_SUB
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PLAN,
		ST_MUL_AB,
		ST_MUL_CD,
		ST_ADD,
		ST_MUL_MU,
		ST_MUL_P,
		ST_SUB,
		ST_FIX,
		ST_WB,
		ST_DONE
	} state_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] entry;
		logic       mode_acc;
		logic       load;
		logic       write_res;
		logic       wb;
		logic       in_ready;
		logic       out_valid;
	} ctrl_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] m00;
		logic [VALUE_BITS-1:0] m01;
		logic [VALUE_BITS-1:0] m10;
		logic [VALUE_BITS-1:0] m11;
	} mat_t;

	function automatic logic [VALUE_BITS-1:0] mat_pick(mat_t m, logic row, logic col);
		logic [VALUE_BITS-1:0] v;
		unique case ({row, col})
			2'b00:   v = m.m00;
			2'b01:   v = m.m01;
			2'b10:   v = m.m10;
			default: v = m.m11;
		endcase
		return v;
	endfunction

endpackage

/* hdl/mfp_arith.sv */
// ----------------------------------------------------------------------------
// mfp_arith
// Shared multiplier with Barrett reduction: forms (a*b + c*d) mod prime.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfp_arith (
	input  logic                             clk,
	input  mfp_pkg::ctrl_t                   ctrl,
	input  logic [mfp_pkg::VALUE_BITS-1:0]   opa,
	input  logic [mfp_pkg::VALUE_BITS-1:0]   opb,
	input  logic [mfp_pkg::VALUE_BITS-1:0]   opc,
	input  logic [mfp_pkg::VALUE_BITS-1:0]   opd,
	output logic [mfp_pkg::VALUE_BITS-1:0]   value
);
	import mfp_pkg::*;

	logic [MUL_BITS-1:0]  mul_a;
	logic [MUL_BITS-1:0]  mul_b;
	logic [PROD_BITS-1:0] mul_p;
	logic [PROD_BITS-1:0] prod_q;
	logic [SUM_BITS-1:0]  sum_q;
	logic [REM_BITS-1:0]  rem_q;
	logic [REM_BITS-1:0]  rem_fix;

	always_comb begin
		unique case (ctrl.op)
			OP_MUL_FIRST: begin
				mul_a = MUL_BITS'(opa);
				mul_b = MUL_BITS'(opb);
			end
			OP_MUL_SECOND: begin
				mul_a = MUL_BITS'(opc);
				mul_b = MUL_BITS'(opd);
			end
			OP_MUL_MU: begin
				// quotient estimate from the top bits of the sum
				mul_a = MUL_BITS'(sum_q[SUM_BITS-1:29]);
				mul_b = BARRETT_MU;
			end
			OP_MUL_P: begin
				mul_a = MUL_BITS'(prod_q[64:33]);
				mul_b = MUL_BITS'(PRIME);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			OP_MUL_FIRST, OP_MUL_MU, OP_MUL_P: begin
				prod_q <= mul_p;
			end
			OP_MUL_SECOND: begin
				prod_q <= mul_p;
				sum_q  <= prod_q[SUM_BITS-1:0];
			end
			OP_ADD: begin
				sum_q <= sum_q + prod_q[SUM_BITS-1:0];
			end
			OP_SUB: begin
				// remainder is below 2^32, so the low bits suffice
				rem_q <= sum_q[REM_BITS-1:0] - prod_q[REM_BITS-1:0];
			end
			default: begin
			end
		endcase
	end

	// estimate is short by at most two multiples of the prime
	always_comb begin
		priority if (rem_q >= PRIME_X2) begin
			rem_fix = rem_q - PRIME_X2;
		end else if (rem_q >= PRIME_X1) begin
			rem_fix = rem_q - PRIME_X1;
		end else begin
			rem_fix = rem_q;
		end
	end

	assign value = rem_fix[VALUE_BITS-1:0];

endmodule

/* hdl/mfp_ctrl.sv */
// ----------------------------------------------------------------------------
// mfp_ctrl
// Sequencer for square-and-multiply over the index bits, one matrix entry
// at a time through the shared arithmetic unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mfp_ctrl (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic [mfp_pkg::INDEX_BITS-1:0]   index,
	input  logic                             out_ready,
	output mfp_pkg::ctrl_t                   ctrl
);
	import mfp_pkg::*;

	state_t                state_q;
	state_t                state_d;
	logic [INDEX_BITS-1:0] n_q;
	logic [INDEX_BITS-1:0] n_d;
	logic [1:0]            entry_q;
	logic [1:0]            entry_d;
	logic                  mode_q;
	logic                  mode_d;
	logic                  upper_set;

	assign upper_set = (n_q[INDEX_BITS-1:1] != '0);

	always_comb begin
		state_d = state_q;
		n_d     = n_q;
		entry_d = entry_q;
		mode_d  = mode_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					n_d     = index;
					state_d = ST_PLAN;
				end
			end
			ST_PLAN: begin
				entry_d = '0;
				mode_d  = n_q[0];
				if (n_q == '0) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_MUL_AB;
				end
			end
			ST_MUL_AB: state_d = ST_MUL_CD;
			ST_MUL_CD: state_d = ST_ADD;
			ST_ADD:    state_d = ST_MUL_MU;
			ST_MUL_MU: state_d = ST_MUL_P;
			ST_MUL_P:  state_d = ST_SUB;
			ST_SUB:    state_d = ST_FIX;
			ST_FIX: begin
				if (&entry_q) begin
					state_d = ST_WB;
				end else begin
					entry_d = entry_q + 2'd1;
					state_d = ST_MUL_AB;
				end
			end
			ST_WB: begin
				entry_d = '0;
				if (mode_q && upper_set) begin
					// accumulator done, square the base next
					mode_d  = 1'b0;
					state_d = ST_MUL_AB;
				end else begin
					n_d     = n_q >> 1;
					state_d = ST_PLAN;
				end
			end
			ST_DONE: begin
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl           = '0;
		ctrl.op        = OP_IDLE;
		ctrl.entry     = entry_q;
		ctrl.mode_acc  = mode_q;
		ctrl.in_ready  = (state_q == ST_IDLE);
		ctrl.load      = (state_q == ST_IDLE) && in_valid;
		ctrl.out_valid = (state_q == ST_DONE);
		ctrl.write_res = (state_q == ST_FIX);
		ctrl.wb        = (state_q == ST_WB);
		unique case (state_q)
			ST_MUL_AB: ctrl.op = OP_MUL_FIRST;
			ST_MUL_CD: ctrl.op = OP_MUL_SECOND;
			ST_ADD:    ctrl.op = OP_ADD;
			ST_MUL_MU: ctrl.op = OP_MUL_MU;
			ST_MUL_P:  ctrl.op = OP_MUL_P;
			ST_SUB:    ctrl.op = OP_SUB;
			default:   ctrl.op = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q     <= '0;
			entry_q <= '0;
			mode_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			n_q     <= n_d;
			entry_q <= entry_d;
			mode_q  <= mode_d;
		end
	end

endmodule

/* hdl/fibonacci_mod_matrix_power.sv */
// ----------------------------------------------------------------------------
// fibonacci_mod_matrix_power
// Returns F(n) modulo 1000000009 for a Fibonacci index n by raising the
// matrix [[1,1],[1,0]] to the power n with square-and-multiply. One index is
// taken per transfer, and s_tready stays low until the result has been
// transferred out; it rises again in the cycle after that transfer. Each 2x2
// matrix product steps each of its entries through ST_MUL_AB, ST_MUL_CD,
// ST_ADD, ST_MUL_MU, ST_MUL_P, ST_SUB and ST_FIX on the single shared
// multiplier and Barrett reducer, plus one write-back. An index needs one
// product per set bit, one squaring per bit below the top set bit, a pass
// through ST_PLAN per bit and a final pass through ST_PLAN. An index of zero
// goes from ST_PLAN straight to ST_DONE and answers 0.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fibonacci_mod_matrix_power (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [mfp_pkg::IN_TDATA_BITS-1:0]    s_tdata,  // [62:0] fib_index
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [mfp_pkg::OUT_TDATA_BITS-1:0]   m_tdata   // [29:0] fib_value
);
	import mfp_pkg::*;

	ctrl_t                 ctrl;
	mat_t                  acc_q;
	mat_t                  base_q;
	mat_t                  res_q;
	mat_t                  lhs;
	logic [VALUE_BITS-1:0] opa;
	logic [VALUE_BITS-1:0] opb;
	logic [VALUE_BITS-1:0] opc;
	logic [VALUE_BITS-1:0] opd;
	logic [VALUE_BITS-1:0] value;

	mfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.index     (s_tdata[INDEX_BITS-1:0]),
		.out_ready (m_tready),
		.ctrl      (ctrl)
	);

	// row of the left operand, column of the base
	assign lhs = ctrl.mode_acc ? acc_q : base_q;
	assign opa = mat_pick(lhs, ctrl.entry[1], 1'b0);
	assign opb = mat_pick(base_q, 1'b0, ctrl.entry[0]);
	assign opc = mat_pick(lhs, ctrl.entry[1], 1'b1);
	assign opd = mat_pick(base_q, 1'b1, ctrl.entry[0]);

	mfp_arith u_arith (
		.clk   (clk),
		.ctrl  (ctrl),
		.opa   (opa),
		.opb   (opb),
		.opc   (opc),
		.opd   (opd),
		.value (value)
	);

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			acc_q  <= '{m00: 30'd1, m01: 30'd0, m10: 30'd0, m11: 30'd1};
			base_q <= '{m00: 30'd1, m01: 30'd1, m10: 30'd1, m11: 30'd0};
		end else if (ctrl.wb) begin
			// commit the finished product to its target
			if (ctrl.mode_acc) begin
				acc_q <= res_q;
			end else begin
				base_q <= res_q;
			end
		end
		if (ctrl.write_res) begin
			unique case (ctrl.entry)
				2'b00:   res_q.m00 <= value;
				2'b01:   res_q.m01 <= value;
				2'b10:   res_q.m10 <= value;
				default: res_q.m11 <= value;
			endcase
		end
	end

	assign s_tready = ctrl.in_ready;
	assign m_tvalid = ctrl.out_valid;
	assign m_tdata  = OUT_TDATA_BITS'(acc_q.m01);

`ifndef SYNTHESIS
	a_busy_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while a result is pending");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("ready held after an input transfer");

	a_result_reduced: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[VALUE_BITS-1:0] < PRIME))
		else $error("result not reduced below the prime");

	a_result_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(m_tvalid) |-> $past(m_tready))
		else $error("result dropped without a transfer");
`endif

endmodule
